/* sv/assert_macros.svh */
// assertion macros used by the checker file hri_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/hri_pkg.sv */
// package for the halton radical inverse block
// holds widths, microcode op and condition codes, and the control store
package hri_pkg;

  localparam int DEF_INDEX_BITS    = 32;
  localparam int DEF_FRACTION_BITS = 32;
  localparam int BASE_W            = 8;

  localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0] RESET_BASE = BASE_W'(2);

  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] upc_t;
  typedef logic [2:0]      op_t;
  typedef logic [2:0]      cond_t;

  // datapath operations
  localparam op_t OP_NOP     = 3'd0;
  localparam op_t OP_LOAD    = 3'd1;
  localparam op_t OP_DIVINIT = 3'd2;
  localparam op_t OP_DIVSTEP = 3'd3;
  localparam op_t OP_ACC     = 3'd4;
  localparam op_t OP_LSTEP   = 3'd5;
  localparam op_t OP_EMIT    = 3'd6;

  // jump conditions
  localparam cond_t C_NEVER     = 3'd0;
  localparam cond_t C_NO_INPUT  = 3'd1;
  localparam cond_t C_IDX_ZERO  = 3'd2;
  localparam cond_t C_DIV_MORE  = 3'd3;
  localparam cond_t C_FRAC_MORE = 3'd4;
  localparam cond_t C_OUT_BUSY  = 3'd5;

  // control store addresses
  localparam upc_t A_IDLE = 3'd0;
  localparam upc_t A_TEST = 3'd1;
  localparam upc_t A_DIV  = 3'd2;
  localparam upc_t A_ACC  = 3'd3;
  localparam upc_t A_LDIV = 3'd4;
  localparam upc_t A_DONE = 3'd5;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  jump;
    upc_t  next;
  } uword_t;

  // control store: next pc is jump when the condition holds, else next
  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    unique case (pc)
      A_IDLE:  w = '{op: OP_LOAD,    cond: C_NO_INPUT,  jump: A_IDLE, next: A_TEST};
      A_TEST:  w = '{op: OP_DIVINIT, cond: C_IDX_ZERO,  jump: A_LDIV, next: A_DIV};
      A_DIV:   w = '{op: OP_DIVSTEP, cond: C_DIV_MORE,  jump: A_DIV,  next: A_ACC};
      A_ACC:   w = '{op: OP_ACC,     cond: C_NEVER,     jump: A_TEST, next: A_TEST};
      A_LDIV:  w = '{op: OP_LSTEP,   cond: C_FRAC_MORE, jump: A_LDIV, next: A_DONE};
      A_DONE:  w = '{op: OP_EMIT,    cond: C_OUT_BUSY,  jump: A_DONE, next: A_IDLE};
      default: w = '{op: OP_NOP,     cond: C_NEVER,     jump: A_IDLE, next: A_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* sv/halton_radical_inverse.sv */
// halton radical inverse: microcoded sequencer with a digit divider and long division
// depends on hri_pkg
//
// Takes one seq_index word and returns one fraction word equal to
// floor(S * 2^FRACTION_BITS), where S is the index's base-p digits mirrored
// about the radix point; p is radix_base, written through cfg_we/cfg_wdata
// (0 and 1 act as 2). Index zero gives zero. Each base-p digit of the
// index goes through the shared divider at eight quotient bits per cycle,
// then a multiply-accumulate step, and the final fraction comes from a
// one-bit-per-cycle long division.
// One item is in flight at a time; the output register lets the next word be
// accepted while a finished result still waits to be taken.
module halton_radical_inverse import hri_pkg::*; #(
  parameter int INDEX_BITS    = DEF_INDEX_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [BASE_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [INDEX_BITS-1:0]    seq_index,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [FRACTION_BITS-1:0] fraction
);

  localparam int DIV_CYCLES = (INDEX_BITS + BASE_W - 1) / BASE_W;
  localparam int QUO_W      = DIV_CYCLES * BASE_W;
  localparam int WIDE_W     = INDEX_BITS + BASE_W;
  localparam int CNT_W      = $clog2(FRACTION_BITS);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_CYCLES - 1);
  localparam logic [CNT_W-1:0] FRAC_LAST = CNT_W'(FRACTION_BITS - 1);

  logic [BASE_W-1:0]        radix_base;
  upc_t                     pc;
  upc_t                     pc_next;
  logic [BASE_W-1:0]        p;
  logic [QUO_W-1:0]         quo;
  logic [BASE_W-1:0]        rmd;
  logic [WIDE_W-1:0]        rev;
  logic [WIDE_W-1:0]        scale;
  logic [FRACTION_BITS-1:0] frac;
  logic [CNT_W-1:0]         cnt;

  uword_t uw;
  logic   in_ready;
  logic   in_fire;
  logic   out_free;
  logic   cond_true;

  logic [BASE_W-1:0] div_r;
  logic [QUO_W-1:0]  div_q;
  logic [BASE_W:0]   div_t;

  logic [WIDE_W+BASE_W-1:0] rev_prod;
  logic [WIDE_W+BASE_W-1:0] scale_prod;
  logic [WIDE_W:0]          ld_shl;
  logic [WIDE_W:0]          ld_diff;
  logic                     ld_ge;

  assign uw       = ucode(pc);
  assign in_ready = (uw.op == OP_LOAD) && !rst;
  assign in_stall = !in_ready;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    unique case (uw.cond)
      C_NEVER:     cond_true = 1'b0;
      C_NO_INPUT:  cond_true = !in_fire;
      C_IDX_ZERO:  cond_true = (quo == '0);
      C_DIV_MORE:  cond_true = (cnt != DIV_LAST);
      C_FRAC_MORE: cond_true = (cnt != FRAC_LAST);
      C_OUT_BUSY:  cond_true = !out_free;
      default:     cond_true = 1'b0;
    endcase
    pc_next = cond_true ? uw.jump : uw.next;
  end

  // eight restoring division steps; dividend bits shift out the top,
  // quotient bits shift in at the bottom
  always_comb begin
    div_r = rmd;
    div_q = quo;
    div_t = '0;
    for (int k = 0; k < BASE_W; k++) begin
      div_t = {div_r, div_q[QUO_W-1]};
      div_q = {div_q[QUO_W-2:0], 1'b0};
      if (div_t >= {1'b0, p}) begin
        div_r    = BASE_W'(div_t - {1'b0, p});
        div_q[0] = 1'b1;
      end else begin
        div_r = div_t[BASE_W-1:0];
      end
    end
  end

  assign rev_prod   = rev * p;
  assign scale_prod = scale * p;

  // one bit of rev / scale per cycle
  assign ld_shl  = {rev, 1'b0};
  assign ld_ge   = ld_shl >= {1'b0, scale};
  assign ld_diff = ld_shl - {1'b0, scale};

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= A_IDLE;
      out_valid  <= 1'b0;
      radix_base <= RESET_BASE;
    end else begin
      pc <= pc_next;
      if (cfg_we) begin
        radix_base <= cfg_wdata;
      end
      if (uw.op == OP_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_LOAD: begin
        if (in_fire) begin
          quo   <= QUO_W'(seq_index);
          p     <= (radix_base < BASE_MIN) ? BASE_MIN : radix_base;
          rev   <= '0;
          scale <= WIDE_W'(1);
        end
      end
      OP_DIVINIT: begin
        rmd  <= '0;
        cnt  <= '0;
        frac <= '0;
      end
      OP_DIVSTEP: begin
        quo <= div_q;
        rmd <= div_r;
        cnt <= cnt + 1'b1;
      end
      OP_ACC: begin
        rev   <= rev_prod[WIDE_W-1:0] + WIDE_W'(rmd);
        scale <= scale_prod[WIDE_W-1:0];
      end
      OP_LSTEP: begin
        rev  <= ld_ge ? ld_diff[WIDE_W-1:0] : ld_shl[WIDE_W-1:0];
        frac <= {frac[FRACTION_BITS-2:0], ld_ge};
        cnt  <= cnt + 1'b1;
      end
      OP_EMIT: begin
        if (out_free) begin
          fraction <= frac;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/hri_checker.sv */
// port-level checks for halton_radical_inverse, attached by bind
// depends on hri_pkg and assert_macros.svh
`include "assert_macros.svh"

module hri_checker import hri_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [FRACTION_BITS-1:0] fraction
);

  // a word held by stall stays put
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "result word dropped")
  `ASSERT_CLK(a_frac_hold, clk, rst, out_valid && out_stall |=> $stable(fraction), "result word changed")

  // reset empties the output register
  `ASSERT_CLK_NR(a_rst_empty, clk, rst |=> !out_valid, "result word after reset")

  // only one word in flight: the block is busy right after taking one
  `ASSERT_CLK(a_one_inflight, clk, rst, in_valid && !in_stall |=> in_stall, "second word taken")

  // an accepted word passes A_TEST, then A_DIV or A_LDIV, before A_DONE emits it, so no result rises early
  `ASSERT_CLK(a_min_latency, clk, rst, in_valid && !in_stall |=> !$rose(out_valid) ##1 !$rose(out_valid), "result too early")

endmodule

bind halton_radical_inverse hri_checker #(.FRACTION_BITS(FRACTION_BITS)) u_hri_checker (.*);
